FILE: rtl/core/can_signal_extractor_unit_defines.svh
// Assertion macros used by the checker of the signal extractor.
`ifndef CAN_SIGNAL_EXTRACTOR_UNIT_DEFINES_SVH
`define CAN_SIGNAL_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication on clk, dropped while rst_n is low.
`define CSE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cse check failed");

// Next-cycle implication on clk, dropped while rst_n is low.
`define CSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cse check failed");

`endif

FILE: rtl/core/cse_pkg.sv
// Shared constants, field offsets and result type of the CAN signal extractor.
package cse_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_OUT     = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_W       = $clog2(MAX_OUT + 1);
    localparam int SCNT_W      = 5;
    localparam int CMP_W       = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;

    // Register indexes
    localparam logic REG_SIGNAL_COUNT = 1'b0;
    localparam logic REG_TYPE_ENABLE  = 1'b1;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // Signal kinds
    localparam logic [1:0] KIND_BOOL   = 2'd0;
    localparam logic [1:0] KIND_UINT8  = 2'd1;
    localparam logic [1:0] KIND_UINT16 = 2'd2;
    localparam logic [1:0] KIND_UNSUP  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OOB       = 2'd1;
    localparam logic [1:0] ST_DLC_SHORT = 2'd2;
    localparam logic [1:0] ST_BAD_DESC  = 2'd3;

    // Input tdata layout
    localparam int IN_W      = 168;
    localparam int OFF_FID   = 0;
    localparam int OFF_DLC   = 32;
    localparam int OFF_PAY   = 36;
    localparam int OFF_EIDX  = 100;
    localparam int OFF_IDENT = 104;
    localparam int OFF_START = 120;
    localparam int OFF_END   = 126;
    localparam int OFF_MIN   = 133;
    localparam int OFF_MAX   = 149;
    localparam int OFF_KIND  = 165;

    // Output tdata layout
    localparam int OUT_W = 40;

    typedef struct packed {
        logic [15:0] ident;
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  status;
    } res_t;

endpackage

FILE: rtl/core/can_signal_extractor_unit.sv
// Top level of the CAN signal extractor: descriptor table and scan sequencer.
// A load beat leaves the block idle; the next beat can be taken at the following edge.
// A frame beat scans min(signal_count, TABLE_DEPTH) entries, one per cycle unless the receiver
// stalls a result, then closes the scan and flushes the last result; the input stays blocked
// until the sequencer is back in idle.
// Reset clears sequencer, output and config registers; table contents stay undefined.
module can_signal_extractor_unit
    import cse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // frame_id, dlc, payload, entry_index, signal_ident, start_bit, end_bit,
    // min_value, max_value, signal_kind, zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    // mode
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_ident, out_value, status, zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // out_kind
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Descriptor table
    logic [31:0] match_ids     [TABLE_DEPTH];
    logic [14:0] bit_layout    [TABLE_DEPTH];
    logic [31:0] value_bounds  [TABLE_DEPTH];
    logic [15:0] signal_idents [TABLE_DEPTH];

    state_t            state_reg, state_next;
    logic [4:0]        sig_count_reg, sig_count_next;
    logic [2:0]        type_en_reg, type_en_next;
    logic [31:0]       fid_reg, fid_next;
    logic [3:0]        dlc_reg, dlc_next;
    logic [63:0]       pay_reg, pay_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    res_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;

    logic              in_beat;
    logic              load_beat;
    logic [IDX_W-1:0]  load_idx;
    logic [IDX_W-1:0]  scan_idx;
    logic [CNT_W-1:0]  limit_in;

    // Extract-and-check unit signals
    logic [5:0]        e_start;
    logic [6:0]        e_end;
    logic [1:0]        e_kind;
    logic [15:0]       e_lo, e_hi;
    logic              e_hit;
    logic              e_dlc_short;
    logic              e_enabled;
    logic [7:0]        e_span;
    logic              e_desc_bad;
    logic [4:0]        e_width;
    logic [16:0]       e_mask;
    logic [15:0]       e_window;
    logic [15:0]       e_raw;
    logic [15:0]       e_val;
    logic              e_emit;
    res_t              e_res;

    logic              out_free;
    logic              scan_done;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign load_beat     = in_beat && (s_axis_tuser == MODE_LOAD);
    assign load_idx      = IDX_W'(s_axis_tdata[OFF_EIDX +: 4]);
    assign scan_idx      = idx_reg[IDX_W-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign limit_in = (CMP_W'(sig_count_reg) < CMP_W'(TABLE_DEPTH))
                    ? CNT_W'(sig_count_reg) : CNT_W'(TABLE_DEPTH);

    assign scan_done = (idx_reg == limit_reg) || (num_reg == NUM_W'(MAX_OUT));

    // Table write; an index beyond the table is dropped
    always_ff @(posedge clk)
    begin
        if (load_beat && (int'(s_axis_tdata[OFF_EIDX +: 4]) < TABLE_DEPTH))
        begin
            match_ids[load_idx]     <= s_axis_tdata[OFF_FID +: 32];
            signal_idents[load_idx] <= s_axis_tdata[OFF_IDENT +: 16];
            bit_layout[load_idx]    <= {s_axis_tdata[OFF_KIND +: 2],
                                        s_axis_tdata[OFF_END +: 7],
                                        s_axis_tdata[OFF_START +: 6]};
            value_bounds[load_idx]  <= {s_axis_tdata[OFF_MAX +: 16],
                                        s_axis_tdata[OFF_MIN +: 16]};
        end
    end

    // Shared unit: evaluates the entry under the scan pointer
    always_comb
    begin
        e_start     = bit_layout[scan_idx][5:0];
        e_end       = bit_layout[scan_idx][12:6];
        e_kind      = bit_layout[scan_idx][14:13];
        e_lo        = value_bounds[scan_idx][15:0];
        e_hi        = value_bounds[scan_idx][31:16];
        e_hit       = (match_ids[scan_idx] == fid_reg);
        e_dlc_short = ({dlc_reg, 3'b000} < e_end);
        e_enabled   = ((e_kind == KIND_BOOL) && type_en_reg[0])
                   || ((e_kind == KIND_UINT8) && type_en_reg[1])
                   || ((e_kind == KIND_UINT16) && type_en_reg[2]);
        e_span      = {1'b0, e_end} - {2'b00, e_start};
        e_desc_bad  = (e_end < {1'b0, e_start}) || (e_span > 8'd15);
        e_width     = e_span[4:0] + 5'd1;
        e_mask      = (17'd1 << e_width) - 17'd1;
        // upper byte falls away naturally past the eighth byte
        e_window    = 16'(pay_reg >> {e_start[5:3], 3'b000});
        e_raw       = (e_kind == KIND_UINT16) ? e_window : {8'h00, e_window[7:0]};
        e_val       = (e_raw >> e_start[2:0]) & e_mask[15:0];

        e_res.ident = signal_idents[scan_idx];
        e_res.kind  = e_kind;
        e_emit      = 1'b0;
        e_res.value = 16'd0;
        e_res.status = ST_OK;
        if (e_hit)
        begin
            if (e_dlc_short)
            begin
                e_emit       = 1'b1;
                e_res.status = ST_DLC_SHORT;
            end
            else if (e_kind == KIND_UNSUP)
            begin
                e_emit       = 1'b1;
                e_res.status = ST_BAD_DESC;
            end
            else if (!e_enabled)
            begin
                e_emit = 1'b0;
            end
            else if (e_desc_bad)
            begin
                e_emit       = 1'b1;
                e_res.status = ST_BAD_DESC;
            end
            else
            begin
                e_emit       = 1'b1;
                e_res.status = ((e_val >= e_lo) && (e_val <= e_hi)) ? ST_OK : ST_OOB;
                e_res.value  = (e_kind == KIND_BOOL) ? {15'd0, (e_val != 16'd0)} : e_val;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        sig_count_next  = sig_count_reg;
        type_en_next    = type_en_reg;
        fid_next        = fid_reg;
        dlc_next        = dlc_reg;
        pay_next        = pay_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SIGNAL_COUNT: sig_count_next = cfg_data;
                REG_TYPE_ENABLE:  type_en_next   = cfg_data[2:0];
                default:          sig_count_next = sig_count_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (s_axis_tuser == MODE_FRAME))
                begin
                    fid_next        = s_axis_tdata[OFF_FID +: 32];
                    dlc_next        = s_axis_tdata[OFF_DLC +: 4];
                    pay_next        = s_axis_tdata[OFF_PAY +: 64];
                    limit_next      = limit_in;
                    idx_next        = '0;
                    num_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!e_emit)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    pend_next       = e_res;
                    pend_valid_next = 1'b1;
                    idx_next        = idx_reg + CNT_W'(1);
                    num_next        = num_reg + NUM_W'(1);
                end
                else if (out_free)
                begin
                    // hand the older result on, hold the new one until its successor shows
                    out_next       = pend_reg;
                    out_last_next  = 1'b0;
                    out_valid_next = 1'b1;
                    pend_next      = e_res;
                    idx_next       = idx_reg + CNT_W'(1);
                    num_next       = num_reg + NUM_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sig_count_reg  <= '0;
            type_en_reg    <= '0;
            fid_reg        <= '0;
            dlc_reg        <= '0;
            pay_reg        <= '0;
            limit_reg      <= '0;
            idx_reg        <= '0;
            num_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sig_count_reg  <= sig_count_next;
            type_en_reg    <= type_en_next;
            fid_reg        <= fid_next;
            dlc_reg        <= dlc_next;
            pay_reg        <= pay_next;
            limit_reg      <= limit_next;
            idx_reg        <= idx_next;
            num_reg        <= num_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.status, out_reg.value, out_reg.ident};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/core/cse_checker.sv
// Port-level checker of the CAN signal extractor, bound to the top level.
`include "can_signal_extractor_unit_defines.svh"

module cse_checker
    import cse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic              s_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [OUT_W-1:0]  m_axis_tdata,
    input  logic [1:0]        m_axis_tuser,
    input  logic              m_axis_tlast
);

    logic              in_beat;
    logic              out_stall;
    logic [OUT_W+2:0]  out_word;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // a stalled result beat holds
    `CSE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

    // a load beat never blocks the next item
    `CSE_ASSERT_NEXT(a_load_quick, in_beat && (s_axis_tuser == MODE_LOAD), s_axis_tready)

    // a frame beat starts a scan
    `CSE_ASSERT_NEXT(a_frame_busy, in_beat && (s_axis_tuser == MODE_FRAME), !s_axis_tready)

    // an offered result beat carries no unknown bits
    `CSE_ASSERT_NOW(a_out_known, m_axis_tvalid, !$isunknown(out_word))

endmodule

bind can_signal_extractor_unit cse_checker u_cse_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for the CAN signal extractor: descriptor loads, frame decoding, results.
module tb;
    import cse_pkg::*;

    typedef struct {
        logic        mode;
        logic [31:0] frame_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [3:0]  entry_index;
        logic [15:0] signal_ident;
        logic [5:0]  start_bit;
        logic [6:0]  end_bit;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [1:0]  signal_kind;
    } can_item_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  status;
        logic        last;
    } signal_result_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_index = REG_SIGNAL_COUNT;
    logic [4:0]       cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = MODE_LOAD;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;

    // Descriptor table and register copies kept by the decoder prediction
    logic [31:0] desc_id    [TABLE_DEPTH];
    logic [15:0] desc_ident [TABLE_DEPTH];
    logic [5:0]  desc_start [TABLE_DEPTH];
    logic [6:0]  desc_end   [TABLE_DEPTH];
    logic [1:0]  desc_kind  [TABLE_DEPTH];
    logic [15:0] desc_min   [TABLE_DEPTH];
    logic [15:0] desc_max   [TABLE_DEPTH];
    logic [4:0]  sig_count = '0;
    logic [2:0]  type_en = '0;

    can_item_t      pending_items[$];
    signal_result_t expected_signals[$];
    can_item_t      driven_item;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_go = 1'b0;
    bit  rx_hold = 1'b0;
    int  fault_count = 0;
    int  loads_sent = 0;
    int  frames_sent = 0;
    int  results_checked = 0;
    int  settings_run = 0;

    can_signal_extractor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [IN_W-1:0] pack_item(can_item_t it);
        logic [IN_W-1:0] word;
        word = '0;
        word[OFF_FID   +: 32] = it.frame_id;
        word[OFF_DLC   +: 4]  = it.dlc;
        word[OFF_PAY   +: 64] = it.payload;
        word[OFF_EIDX  +: 4]  = it.entry_index;
        word[OFF_IDENT +: 16] = it.signal_ident;
        word[OFF_START +: 6]  = it.start_bit;
        word[OFF_END   +: 7]  = it.end_bit;
        word[OFF_MIN   +: 16] = it.min_value;
        word[OFF_MAX   +: 16] = it.max_value;
        word[OFF_KIND  +: 2]  = it.signal_kind;
        return word;
    endfunction

    function automatic logic [7:0] payload_byte(logic [63:0] payload, int idx);
        if (idx >= 8)
            return 8'h00;
        return payload[idx*8 +: 8];
    endfunction

    // Apply a load to the table copy, or queue the results a frame decodes to.
    task automatic decode_item(input can_item_t it);
        int             scan_len;
        int             width;
        int             lo_byte;
        logic [15:0]    raw;
        logic [15:0]    val;
        logic [31:0]    mask;
        signal_result_t res;
        signal_result_t batch[$];
        if (it.mode == MODE_LOAD)
        begin
            desc_id[it.entry_index]    = it.frame_id;
            desc_ident[it.entry_index] = it.signal_ident;
            desc_start[it.entry_index] = it.start_bit;
            desc_end[it.entry_index]   = it.end_bit;
            desc_kind[it.entry_index]  = it.signal_kind;
            desc_min[it.entry_index]   = it.min_value;
            desc_max[it.entry_index]   = it.max_value;
            return;
        end
        scan_len = (sig_count < TABLE_DEPTH) ? int'(sig_count) : TABLE_DEPTH;
        for (int i = 0; i < scan_len && batch.size() < MAX_OUT; i++)
        begin
            if (desc_id[i] != it.frame_id)
                continue;
            res.ident  = desc_ident[i];
            res.kind   = desc_kind[i];
            res.value  = '0;
            res.last   = 1'b0;
            width = int'(desc_end[i]) - int'(desc_start[i]) + 1;
            if (int'(it.dlc) * 8 < int'(desc_end[i]))
                res.status = ST_DLC_SHORT;
            else if (desc_kind[i] == KIND_UNSUP)
                res.status = ST_BAD_DESC;
            else if (!type_en[desc_kind[i]])
                continue;
            else if (desc_end[i] < desc_start[i] || width > 16)
                res.status = ST_BAD_DESC;
            else
            begin
                lo_byte = int'(desc_start[i]) / 8;
                raw = '0;
                raw[7:0] = payload_byte(it.payload, lo_byte);
                if (desc_kind[i] == KIND_UINT16)
                    raw[15:8] = payload_byte(it.payload, lo_byte + 1);
                mask = (32'd1 << width) - 32'd1;
                val = (raw >> desc_start[i][2:0]) & mask[15:0];
                res.status = (val >= desc_min[i] && val <= desc_max[i]) ? ST_OK : ST_OOB;
                res.value = (desc_kind[i] == KIND_BOOL) ? {15'd0, val != 16'd0} : val;
            end
            batch.push_back(res);
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            expected_signals.push_back(batch[k]);
    endtask

    // Sender: hold the beat until taken, then pick the next one or idle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_item(driven_item);
                if (driven_item.mode == MODE_LOAD)
                    loads_sent++;
                else
                    frames_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    driven_item = pending_items.pop_front();
                    s_axis_tdata  <= pack_item(driven_item);
                    s_axis_tuser  <= driven_item.mode;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken beat against the oldest expected result.
    always @(posedge clk)
    begin
        signal_result_t want;
        signal_result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ident  = m_axis_tdata[15:0];
                got.value  = m_axis_tdata[31:16];
                got.status = m_axis_tdata[33:32];
                got.kind   = m_axis_tuser;
                got.last   = m_axis_tlast;
                if (expected_signals.size() == 0)
                begin
                    $error("unexpected result: ident %0h value %0h status %0d",
                           got.ident, got.value, got.status);
                    fault_count++;
                end
                else
                begin
                    want = expected_signals.pop_front();
                    results_checked++;
                    if (got.ident !== want.ident)
                    begin
                        $error("out_ident: expected %0h, got %0h", want.ident, got.ident);
                        fault_count++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                        fault_count++;
                    end
                    if (got.value !== want.value)
                    begin
                        $error("out_value: expected %0h, got %0h", want.value, got.value);
                        fault_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fault_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fault_count++;
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SIGNAL_COUNT)
            sig_count = val;
        else
            type_en = val[2:0];
    endtask

    // Wait for every result, then give a scan with no result time to finish.
    task automatic settle_block();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_signals.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic can_item_t load_desc(int idx, logic [31:0] id, logic [15:0] ident,
                                            logic [1:0] kind, int sb, int eb,
                                            logic [15:0] lo, logic [15:0] hi);
        can_item_t it;
        it = '{default: '0};
        it.mode         = MODE_LOAD;
        it.entry_index  = 4'(idx);
        it.frame_id     = id;
        it.signal_ident = ident;
        it.signal_kind  = kind;
        it.start_bit    = 6'(sb);
        it.end_bit      = 7'(eb);
        it.min_value    = lo;
        it.max_value    = hi;
        return it;
    endfunction

    function automatic can_item_t frame_item(logic [31:0] id, logic [3:0] dlc,
                                             logic [63:0] payload);
        can_item_t it;
        it = '{default: '0};
        it.mode     = MODE_FRAME;
        it.frame_id = id;
        it.dlc      = dlc;
        it.payload  = payload;
        return it;
    endfunction

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0123;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'h0000_07FF;
        endcase
    endfunction

    // Frames mostly hit ids in the table; loads draw well-formed layouts with some broken ones.
    function automatic can_item_t random_item();
        can_item_t  it;
        int         sb;
        int         w;
        logic [1:0] kind;
        if ($urandom_range(0, 99) < 20)
        begin
            sb = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0, 1: w = $urandom_range(0, 64) - sb + 1;
                2: w = $urandom_range(17, 30);
                default: w = $urandom_range(1, 16);
            endcase
            if (sb + w - 1 > 64)
                w = 65 - sb;
            kind = ($urandom_range(0, 9) == 0) ? KIND_UNSUP : 2'($urandom_range(0, 2));
            it = load_desc($urandom_range(0, 15), pick_id(),
                           16'($urandom_range(0, 16'hFFFF)), kind,
                           sb, (sb + w - 1 < 0) ? 0 : sb + w - 1, 16'd0, 16'hFFFF);
            case ($urandom_range(0, 2))
                0: ;
                1:
                begin
                    it.min_value = 16'($urandom_range(0, 16'hFFFF));
                    it.max_value = 16'($urandom_range(0, 16'hFFFF));
                end
                default:
                begin
                    it.min_value = 16'($urandom_range(0, 16'h3F));
                    it.max_value = it.min_value + 16'($urandom_range(0, 16'h7F));
                end
            endcase
        end
        else
        begin
            it = frame_item(($urandom_range(0, 99) < 85) ? pick_id() : $urandom(),
                            ($urandom_range(0, 99) < 60) ? 4'd8 : 4'($urandom_range(0, 7)),
                            {$urandom(), $urandom()});
        end
        return it;
    endfunction

    task automatic run_phase(input logic [4:0] count, input logic [2:0] en,
                             input int idle, input int stall, input int n_items,
                             input bit hold, input bit pause_mid);
        settle_block();
        write_reg(REG_SIGNAL_COUNT, count);
        write_reg(REG_TYPE_ENABLE, {2'b00, en});
        @(negedge clk);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        settings_run++;
        if (hold)
            hold_go = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if (pause_mid && k == n_items / 2)
                settle_block();
            pending_items.push_back(random_item());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_reg(REG_SIGNAL_COUNT, 5'd16);
        write_reg(REG_TYPE_ENABLE, 5'd7);
        settings_run = 1;
        @(negedge clk);
        // Fill every slot before any frame so the scan never reads an unloaded entry
        pending_items.push_back(load_desc(0, 32'h123, 16'h0001, KIND_BOOL, 0, 0, 0, 1));
        pending_items.push_back(load_desc(1, 32'h123, 16'h0002, KIND_UINT8, 8, 15,
                                          16'h0000, 16'hFFFF));
        pending_items.push_back(load_desc(2, 32'h123, 16'h0003, KIND_UINT16, 16, 31,
                                          16'h0010, 16'h8000));
        pending_items.push_back(load_desc(3, 32'h123, 16'h0004, KIND_UINT8, 36, 39, 5, 5));
        pending_items.push_back(load_desc(4, 32'h123, 16'h0005, KIND_UNSUP, 0, 7, 0, 255));
        pending_items.push_back(load_desc(5, 32'h123, 16'h0006, KIND_UINT8, 20, 10, 0, 255));
        pending_items.push_back(load_desc(6, 32'h123, 16'h0007, KIND_UINT16, 0, 16,
                                          16'h0000, 16'hFFFF));
        pending_items.push_back(load_desc(7, 32'h123, 16'h0008, KIND_UINT16, 57, 64,
                                          16'h0000, 16'h00FF));
        pending_items.push_back(load_desc(8, 32'h123, 16'h0009, KIND_UINT16, 49, 64,
                                          16'hFFFF, 16'hFFFF));
        pending_items.push_back(load_desc(9, 32'hFFFF_FFFF, 16'hFFFF, KIND_UINT8, 63, 63,
                                          16'h0000, 16'h0000));
        pending_items.push_back(load_desc(10, 32'hFFFF_FFFF, 16'h0000, KIND_BOOL, 7, 7, 1, 1));
        pending_items.push_back(load_desc(11, 32'h0, 16'h8000, KIND_UINT16, 3, 18,
                                          16'h0100, 16'hF000));
        pending_items.push_back(load_desc(12, 32'h7FF, 16'h1234, KIND_UINT8, 0, 7, 0, 255));
        pending_items.push_back(load_desc(13, 32'h7FF, 16'h5678, KIND_UINT16, 48, 63,
                                          16'h0000, 16'hFFFF));
        pending_items.push_back(load_desc(14, 32'h7FF, 16'h9ABC, KIND_BOOL, 62, 63, 0, 0));
        pending_items.push_back(load_desc(15, 32'h7FF, 16'hDEF0, KIND_UINT8, 60, 64, 0, 31));
        pending_items.push_back(frame_item(32'h123, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(frame_item(32'h123, 4'd8, 64'h0000_0000_0000_0000));
        pending_items.push_back(frame_item(32'h123, 4'd8, 64'h8001_0050_0120_AB01));
        pending_items.push_back(frame_item(32'h123, 4'd2, 64'h0123_4567_89AB_CDEF));
        pending_items.push_back(frame_item(32'h123, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(frame_item(32'hFFFF_FFFF, 4'd8, 64'h8000_0000_0000_0080));
        pending_items.push_back(frame_item(32'h0, 4'd3, 64'h0000_0000_00A5_5A5A));
        pending_items.push_back(frame_item(32'h7FF, 4'd8, 64'hC3A5_0000_0000_0042));
        pending_items.push_back(frame_item(32'h555, 4'd8, 64'hDEAD_BEEF_CAFE_F00D));

        run_phase(5'd16, 3'd7, 0, 0, 16, 1'b0, 1'b0);
        run_phase(5'd0, 3'd7, 45, 0, 8, 1'b0, 1'b0);
        run_phase(5'd31, 3'd5, 0, 45, 16, 1'b0, 1'b0);
        run_phase(5'd1, 3'd0, 26, 26, 10, 1'b0, 1'b0);
        run_phase(5'd9, 3'd2, 45, 0, 16, 1'b0, 1'b0);
        run_phase(5'd16, 3'd3, 0, 0, 20, 1'b1, 1'b0);
        run_phase(5'd12, 3'd6, 26, 26, 19, 1'b0, 1'b1);
        settle_block();

        if (expected_signals.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_signals.size());
            fault_count++;
        end
        $display("Covered %0d descriptor loads and %0d frames over %0d register settings,",
                 loads_sent, frames_sent, settings_run);
        $display("with %0d decoded signals checked under mixed sender and receiver stalls.",
                 results_checked);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
